// ===== rtl/core/pptp_pkg.sv =====
// ----------------------------------------------------------------------------
// pptp_pkg
// Shared types and constants of the path pointer token parser.
// ----------------------------------------------------------------------------
package pptp_pkg;

  // Width of the index accumulator; a segment above 2^IndexBits - 1 is no index.
  localparam int unsigned IndexBits = 32;

  localparam logic [7:0] CharSlash = 8'h2F;  // '/'
  localparam logic [7:0] CharTilde = 8'h7E;  // '~'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharOne   = 8'h31;  // '1'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [3:0] Radix     = 4'd10;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_SEG  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_in;
    logic       end_of_path;
  } in_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  char_out;
    logic        is_index;
    logic [31:0] index_value;
    logic        path_done;
    logic        last_of_run;
  } out_t;

  // Classified work for the back end: an optional character or mid-path
  // segment end, followed by an optional path-end result.
  typedef struct packed {
    logic       has_first;
    logic       first_is_seg;
    logic [7:0] chr;
    logic       has_fin;
    logic       fin_err;
  } op_t;

endpackage

// ===== rtl/core/pptp_front.sv =====
// ----------------------------------------------------------------------------
// pptp_front
// Accepts raw path bytes, resolves escapes and slashes, issues back-end ops.
// ----------------------------------------------------------------------------
module pptp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pptp_pkg::in_t in_req_i,
  output logic          op_valid_o,
  output pptp_pkg::op_t op_o,
  input  logic          op_ready_i
);

  logic start_q, start_d;
  logic esc_q, esc_d;
  logic drop_q, drop_d;
  logic accept;
  pptp_pkg::op_t op;

  assign in_ready_o = op_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [7:0] c;
    c       = in_req_i.char_in;
    start_d = start_q;
    esc_d   = esc_q;
    drop_d  = drop_q;
    op      = '0;

    if (in_req_i.has_char && !drop_q) begin
      start_d = 1'b0;
      if (start_q && c == pptp_pkg::CharSlash) begin
        // skip the single leading slash
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (c == pptp_pkg::CharZero) begin
          op.has_first = 1'b1;
          op.chr       = pptp_pkg::CharTilde;
        end else if (c == pptp_pkg::CharOne) begin
          op.has_first = 1'b1;
          op.chr       = pptp_pkg::CharSlash;
        end else begin
          drop_d = 1'b1;
        end
      end else if (c == pptp_pkg::CharSlash) begin
        op.has_first    = 1'b1;
        op.first_is_seg = 1'b1;
      end else if (c == pptp_pkg::CharTilde) begin
        esc_d = 1'b1;
      end else begin
        op.has_first = 1'b1;
        op.chr       = c;
      end
    end

    if (in_req_i.end_of_path) begin
      // an escape still open or a bad escape at path end spoils the path
      if (esc_d || drop_d) begin
        op.has_fin = 1'b1;
        op.fin_err = 1'b1;
      end else if (!start_d) begin
        op.has_fin = 1'b1;
      end
      start_d = 1'b1;
      esc_d   = 1'b0;
      drop_d  = 1'b0;
    end
  end

  assign op_o       = op;
  assign op_valid_o = in_valid_i && (op.has_first || op.has_fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      esc_q   <= 1'b0;
      drop_q  <= 1'b0;
    end else if (accept) begin
      start_q <= start_d;
      esc_q   <= esc_d;
      drop_q  <= drop_d;
    end
  end

endmodule

// ===== rtl/core/pptp_queue.sv =====
// ----------------------------------------------------------------------------
// pptp_queue
// Two-entry queue of ops between the front and the back end.
// ----------------------------------------------------------------------------
module pptp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pptp_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  output pptp_pkg::op_t pop_op_o,
  input  logic          pop_ready_i
);

  pptp_pkg::op_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_op_o     = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/pptp_back.sv =====
// ----------------------------------------------------------------------------
// pptp_back
// Executes ops: tracks segment index state and drives the result register.
// ----------------------------------------------------------------------------
module pptp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  pptp_pkg::op_t  op_i,
  output logic           op_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pptp_pkg::out_t out_req_o
);

  localparam int unsigned AccW = pptp_pkg::IndexBits;

  logic phase_q;
  logic len_nz_q, len_nz_d;
  logic multi_q, multi_d;
  logic lz_q, lz_d;
  logic valid_idx_q, valid_idx_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic out_valid_q;
  pptp_pkg::out_t out_q, res;
  logic load, step, do_first;

  assign load     = !out_valid_q || out_ready_i;
  assign step     = op_valid_i && load;
  assign do_first = !phase_q && op_i.has_first;
  // pop once the last result of the op has gone to the output register
  assign op_ready_o = load && !(do_first && op_i.has_fin);

  always_comb begin
    logic [AccW+3:0] prod;
    logic [3:0]      dig;
    logic            ok;
    logic            is_seg, is_err, done;
    prod        = '0;
    dig         = '0;
    ok          = 1'b0;
    len_nz_d    = len_nz_q;
    multi_d     = multi_q;
    lz_d        = lz_q;
    valid_idx_d = valid_idx_q;
    acc_d       = acc_q;
    res         = '0;

    is_seg = do_first ? op_i.first_is_seg : !op_i.fin_err;
    is_err = !do_first && op_i.fin_err;
    done   = !do_first;
    res.last_of_run = !(do_first && op_i.has_fin);

    if (do_first && !op_i.first_is_seg) begin
      res.result_kind = pptp_pkg::KIND_CHAR;
      res.char_out    = op_i.chr;
      if (!len_nz_q) begin
        lz_d = (op_i.chr == pptp_pkg::CharZero);
      end else begin
        multi_d = 1'b1;
      end
      len_nz_d = 1'b1;
      if (op_i.chr < pptp_pkg::CharZero || op_i.chr > pptp_pkg::CharNine) begin
        valid_idx_d = 1'b0;
        acc_d       = '0;
      end else if (valid_idx_q) begin
        dig  = 4'(op_i.chr - pptp_pkg::CharZero);
        // times ten as two shifts and an add; the top bits flag overflow
        prod = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + (AccW + 4)'(dig);
        if (|prod[AccW+3:AccW]) begin
          valid_idx_d = 1'b0;
          acc_d       = '0;
        end else begin
          acc_d = prod[AccW-1:0];
        end
      end
    end else begin
      if (is_err) begin
        res.result_kind = pptp_pkg::KIND_ERR;
      end else if (is_seg) begin
        ok = len_nz_q && valid_idx_q && !(lz_q && multi_q);
        res.result_kind = pptp_pkg::KIND_SEG;
        res.is_index    = ok;
        res.index_value = ok ? 32'(acc_q) : 32'd0;
      end
      res.path_done = done;
      // segment end or path end: start a fresh segment
      len_nz_d    = 1'b0;
      multi_d     = 1'b0;
      lz_d        = 1'b0;
      valid_idx_d = 1'b1;
      acc_d       = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      len_nz_q    <= 1'b0;
      multi_q     <= 1'b0;
      lz_q        <= 1'b0;
      valid_idx_q <= 1'b1;
      acc_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= op_valid_i;
      end
      if (step) begin
        phase_q     <= do_first && op_i.has_fin;
        len_nz_q    <= len_nz_d;
        multi_q     <= multi_d;
        lz_q        <= lz_d;
        valid_idx_q <= valid_idx_d;
        acc_q       <= acc_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== rtl/core/path_pointer_token_parser_core.sv =====
// ----------------------------------------------------------------------------
// path_pointer_token_parser_core
// Splits a byte-serial path into unescaped characters and segment ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i) takes one request per
//   cycle while in_ready_o is high: an optional path byte plus an end-of-path
//   flag. Output channel (out_valid_o / out_ready_i / out_req_o) returns zero,
//   one or two results per request; last_of_run marks the final result of a
//   request. Path: when the output is free, each op is written into the op
//   queue and then into the output register, which drives out_valid_o.
//   Throughput: one request per cycle while the receiver keeps up, as long as
//   each gives at most one result; a request with two results holds the single
//   output register for both in turn, and the two-entry op queue between
//   front and back end absorbs the difference.
//   Receiver stall: the output register holds its result, the back end stops,
//   the queue fills, and in_ready_o drops once the queue is full.
//   Reset: all state returns to the start of a path; no result is pending.
//   Characters already emitted for a segment of a path that ends in an error
//   result must be discarded by the receiver.
// ----------------------------------------------------------------------------
module path_pointer_token_parser_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pptp_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pptp_pkg::out_t out_req_o
);

  logic          fq_valid, fq_ready;
  pptp_pkg::op_t fq_op;
  logic          qb_valid, qb_ready;
  pptp_pkg::op_t qb_op;

  // Front: classify bytes, track slash/escape/drop state, push ops.
  pptp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .op_valid_o (fq_valid),
    .op_o       (fq_op),
    .op_ready_i (fq_ready)
  );

  // Decouple: hold ops while the back end waits on the receiver.
  pptp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_op_i    (fq_op),
    .pop_valid_o  (qb_valid),
    .pop_op_o     (qb_op),
    .pop_ready_i  (qb_ready)
  );

  // Back: advance index state and emit one result per cycle while the receiver takes them.
  pptp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (qb_valid),
    .op_i        (qb_op),
    .op_ready_o  (qb_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
